/* src/qsrp_pkg.sv */
// shared constants and types for the random-pivot quicksort block
// no dependencies; compiled first
package qsrp_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // pivot generator: 16-bit galois lfsr
    localparam int              LFSR_W    = 16;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    // control bits of one result beat, core to output register
    typedef struct packed {
        logic valid;
        logic final_result;
        logic overflowed;
    } t_emit_ctl;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] n;
        n = s >> 1;
        if (s[0]) begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

endpackage

/* src/qsrp_if.sv */
// valid/ready channel interfaces for input items and result items
// depends on qsrp_pkg for default widths
interface qsrp_in_if
    import qsrp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] value;
    logic                  last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface qsrp_out_if
    import qsrp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] sorted_value;
    logic                  final_result;
    logic                  overflowed;

    modport source (output valid, output sorted_value, output final_result,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input final_result,
                    input overflowed, output ready);
endinterface

/* src/quick_sort_random_pivot.sv */
// top level of the random-pivot quicksort block: core plus result register
// depends on qsrp_pkg, qsrp_if, qsrp_core
//
// usage
// - i_item carries one signed value per beat; last_item marks the final
//   value of a run and starts the sort. values past DEPTH are dropped and
//   every result of that run then shows overflowed
// - o_result gives the stored values in ascending order, one per beat,
//   final_result set on the last one; then the block takes a new run
// - loading takes one beat per cycle; i_item.ready is low from the last
//   beat until the last result has been handed to the output register
// - each partition waits on the bit-serial lfsr mod length unit, then
//   scans its range with a registered read and a compare per element and
//   a swap for each smaller one; all-equal values make this the slowest
//   case for the run
// - each result is emitted by a registered store read, then a load of
//   the output register
// - a stalled receiver holds the result register; the core waits until it
//   frees, nothing is lost or repeated
// - synchronous active-low reset empties the store count, clears the
//   overflow mark and the result valid, and seeds the pivot lfsr
module quick_sort_random_pivot
    import qsrp_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qsrp_in_if.sink    i_item,
    qsrp_out_if.source o_result
);
    t_emit_ctl             emit;
    logic [DATA_WIDTH-1:0] emit_value;
    logic                  take;

    // result register state
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_sorted_value;
    logic                  r_final_result;
    logic                  r_overflowed;

    qsrp_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .o_emit       (emit),
        .o_emit_value (emit_value),
        .i_emit_take  (take)
    );

    // a new result goes in when the register is empty or draining this cycle
    assign take = emit.valid && (!r_out_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_sorted_value <= emit_value;
            r_final_result <= emit.final_result;
            r_overflowed   <= emit.overflowed;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.sorted_value = r_sorted_value;
    assign o_result.final_result = r_final_result;
    assign o_result.overflowed   = r_overflowed;

endmodule

/* src/qsrp_pivot.sv */
// pivot offset unit: lfsr plus bit-serial remainder lfsr mod len
// depends on qsrp_pkg
module qsrp_pivot
    import qsrp_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [$clog2(DEPTH+1)-1:0]   i_len,
    output logic                         o_done,
    output logic [$clog2(DEPTH)-1:0]     o_rem
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int KW = $clog2(LFSR_W);

    logic [LFSR_W-1:0] r_lfsr;
    logic [LFSR_W-1:0] r_div;
    logic [CW-1:0]     r_rem;
    logic [CW-1:0]     r_len;
    logic [KW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [CW:0]       n_trial;
    logic [CW:0]       n_diff;

    // one quotient bit per cycle
    always_comb begin
        n_trial = {r_rem, r_div[LFSR_W-1]};
        n_diff  = n_trial - {1'b0, r_len};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= LFSR_SEED;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_div  <= r_lfsr;
                r_lfsr <= lfsr_next(r_lfsr);
                r_len  <= i_len;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (n_trial >= {1'b0, r_len}) begin
                    r_rem <= n_diff[CW-1:0];
                end else begin
                    r_rem <= n_trial[CW-1:0];
                end
                r_div <= r_div << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == KW'(LFSR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[AW-1:0];

endmodule

/* src/qsrp_core.sv */
// load, partition and emit sequencer with the element store and range stack
// depends on qsrp_pkg, qsrp_if, qsrp_pivot
module qsrp_core
    import qsrp_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    qsrp_in_if.sink               i_item,
    output t_emit_ctl             o_emit,
    output logic [DATA_WIDTH-1:0] o_emit_value,
    input  logic                  i_emit_take
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_START, S_POP, S_MOD, S_SW1, S_SW2, S_SCAN_RD, S_SCAN_CMP,
        S_SCAN_SW2, S_FIN1, S_FIN2, S_EMIT_RD, S_EMIT_WR
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic           r_drop, n_drop;
    logic [CW-1:0]  r_sp, n_sp;
    logic [AW-1:0]  r_lo, n_lo, r_hi, n_hi, r_i, n_i, r_idx, n_idx;
    logic [AW-1:0]  r_pv_idx, n_pv_idx, r_k, n_k;
    logic [DATA_WIDTH-1:0] r_piv, n_piv;

    // element store, two registered read ports, one write port
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_a, r_rd_b;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_wa, mem_ra, mem_rb;
    logic [DATA_WIDTH-1:0] mem_wd;

    // range stack
    logic [AW-1:0] r_stk_lo [DEPTH];
    logic [AW-1:0] r_stk_hi [DEPTH];
    logic          stk_we1, stk_we2;
    logic [AW-1:0] stk_a1, stk_a2, stk_lo1, stk_hi1, stk_lo2, stk_hi2;
    logic [AW-1:0] sp_top;

    logic          piv_start, piv_done;
    logic [CW-1:0] piv_len;
    logic [AW-1:0] piv_rem;

    logic          accept, push1, push2, is_last;
    logic [AW-1:0] pv_sum;

    qsrp_pivot #(.DEPTH(DEPTH)) u_pivot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (piv_start),
        .i_len   (piv_len),
        .o_done  (piv_done),
        .o_rem   (piv_rem)
    );

    assign i_item.ready = (r_state == S_LOAD);
    assign accept       = i_item.valid && (r_state == S_LOAD);
    assign sp_top       = AW'(r_sp - 1'b1);
    assign pv_sum       = r_lo + piv_rem;
    assign is_last      = (CW'(r_k) + 1'b1) == r_count;

    // split the range around the final pivot slot
    assign push1 = (r_idx > r_lo) && ((r_idx - 1'b1) > r_lo);
    assign push2 = (CW'(r_idx) + 1'b1) < CW'(r_hi);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_drop   = r_drop;
        n_sp     = r_sp;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_i      = r_i;
        n_idx    = r_idx;
        n_pv_idx = r_pv_idx;
        n_k      = r_k;
        n_piv    = r_piv;
        mem_we   = 1'b0;
        mem_wa   = r_idx;
        mem_wd   = r_rd_a;
        mem_re   = 1'b0;
        mem_ra   = r_hi;
        mem_rb   = r_idx;
        stk_we1  = 1'b0;
        stk_we2  = 1'b0;
        stk_a1   = r_sp[AW-1:0];
        stk_a2   = r_sp[AW-1:0];
        stk_lo1  = r_lo;
        stk_hi1  = AW'(r_idx - 1'b1);
        stk_lo2  = AW'(r_idx + 1'b1);
        stk_hi2  = r_hi;
        piv_start = 1'b0;
        piv_len   = CW'(r_stk_hi[sp_top]) - CW'(r_stk_lo[sp_top]) + 1'b1;
        o_emit    = '0;

        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (r_count < CW'(DEPTH)) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_count[AW-1:0];
                        mem_wd  = i_item.value;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_item.last_item) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (r_count >= CW'(2)) begin
                    stk_we1 = 1'b1;
                    stk_a1  = '0;
                    stk_lo1 = '0;
                    stk_hi1 = AW'(r_count - 1'b1);
                    n_sp    = CW'(1);
                end else begin
                    n_sp = '0;
                end
                n_state = S_POP;
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_k     = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_lo      = r_stk_lo[sp_top];
                    n_hi      = r_stk_hi[sp_top];
                    n_sp      = r_sp - 1'b1;
                    piv_start = 1'b1;
                    n_state   = S_MOD;
                end
            end
            S_MOD: begin
                if (piv_done) begin
                    mem_re   = 1'b1;
                    mem_ra   = r_hi;
                    mem_rb   = pv_sum;
                    n_pv_idx = pv_sum;
                    n_state  = S_SW1;
                end
            end
            S_SW1: begin
                // pivot value moves to the top of the range
                mem_we  = 1'b1;
                mem_wa  = r_hi;
                mem_wd  = r_rd_b;
                n_piv   = r_rd_b;
                n_state = S_SW2;
            end
            S_SW2: begin
                mem_we  = 1'b1;
                mem_wa  = r_pv_idx;
                mem_wd  = r_rd_a;
                n_i     = r_lo;
                n_idx   = r_lo;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                mem_re = 1'b1;
                mem_rb = r_idx;
                if (r_i == r_hi) begin
                    mem_ra  = r_hi;
                    n_state = S_FIN1;
                end else begin
                    mem_ra  = r_i;
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if ($signed(r_rd_a) < $signed(r_piv)) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_i;
                    mem_wd  = r_rd_b;
                    n_state = S_SCAN_SW2;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_SW2: begin
                mem_we  = 1'b1;
                mem_wa  = r_idx;
                mem_wd  = r_rd_a;
                n_idx   = r_idx + 1'b1;
                n_i     = r_i + 1'b1;
                n_state = S_SCAN_RD;
            end
            S_FIN1: begin
                mem_we  = 1'b1;
                mem_wa  = r_hi;
                mem_wd  = r_rd_b;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                mem_we  = 1'b1;
                mem_wa  = r_idx;
                mem_wd  = r_rd_a;
                // at most count disjoint ranges pend, so the stack never fills
                stk_we1 = push1;
                stk_we2 = push2;
                stk_a2  = AW'(r_sp + CW'(push1));
                n_sp    = r_sp + CW'(push1) + CW'(push2);
                n_state = S_POP;
            end
            S_EMIT_RD: begin
                mem_re  = 1'b1;
                mem_ra  = r_k;
                n_state = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                o_emit.valid        = 1'b1;
                o_emit.final_result = is_last;
                o_emit.overflowed   = r_drop;
                if (i_emit_take) begin
                    if (is_last) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_sp    = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_emit_value = r_rd_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_sp    <= n_sp;
        end
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_i      <= n_i;
        r_idx    <= n_idx;
        r_pv_idx <= n_pv_idx;
        r_k      <= n_k;
        r_piv    <= n_piv;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_a <= r_mem[mem_ra];
            r_rd_b <= r_mem[mem_rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we1) begin
            r_stk_lo[stk_a1] <= stk_lo1;
            r_stk_hi[stk_a1] <= stk_hi1;
        end
        if (stk_we2) begin
            r_stk_lo[stk_a2] <= stk_lo2;
            r_stk_hi[stk_a2] <= stk_hi2;
        end
    end

endmodule

/* test/quick_sort_random_pivot_tb.sv */
// self-checking testbench for the random-pivot quicksort block
// uses qsrp_pkg, the qsrp_in_if / qsrp_out_if channels and quick_sort_random_pivot
// a shadow store mirrors each load run and sorts it when the run closes
module quick_sort_random_pivot_tb;
    import qsrp_pkg::*;

    localparam int DW          = DATA_WIDTH_DEF;
    localparam int DEPTH       = DEPTH_DEF;
    // covers the worst-case sorting of a run plus stalled emission
    localparam int CYCLE_LIMIT = 400000;
    // items of random runs per idling phase
    localparam int PHASE_ITEMS = 50;

    // one beat toward the block: a value and the end-of-run mark
    typedef struct {
        logic [DW-1:0] value;
        logic          is_last;
    } t_load_beat;

    // one sorted beat the block must hand back
    typedef struct {
        logic [DW-1:0] value;
        logic          is_final;
        logic          overflowed;
    } t_sorted_beat;

    logic i_clk;
    logic i_rst_n;

    qsrp_in_if  #(.DATA_WIDTH(DW)) item_if ();
    qsrp_out_if #(.DATA_WIDTH(DW)) result_if ();

    quick_sort_random_pivot #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DW)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // beats waiting to be offered, filled by the stimulus block
    t_load_beat   load_q[$];
    t_load_beat   next_load;
    // sorted beats predicted but not yet seen on the result channel
    t_sorted_beat sorted_pending_q[$];

    // shadow of the block's store for the run being loaded
    logic signed [DW-1:0] shadow_store [DEPTH];
    int                   shadow_count;
    bit                   shadow_dropped;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // store one accepted beat; on the end-of-run mark sort the shadow and
    // queue every value in ascending order
    task automatic load_and_sort(input logic [DW-1:0] v, input logic is_last);
        int                   i;
        int                   j;
        logic signed [DW-1:0] key;
        t_sorted_beat         beat;
        if (shadow_count < DEPTH) begin
            shadow_store[shadow_count] = v;
            shadow_count++;
        end else begin
            // store full: the value is lost and the whole run is marked
            shadow_dropped = 1'b1;
        end
        if (is_last) begin
            // plain insertion sort, signed compare; pivot choice cannot matter
            for (i = 1; i < shadow_count; i++) begin
                key = shadow_store[i];
                j = i - 1;
                while (j >= 0 && shadow_store[j] > key) begin
                    shadow_store[j + 1] = shadow_store[j];
                    j--;
                end
                shadow_store[j + 1] = key;
            end
            for (i = 0; i < shadow_count; i++) begin
                beat.value      = shadow_store[i];
                beat.is_final   = (i == shadow_count - 1);
                beat.overflowed = shadow_dropped;
                sorted_pending_q.insert(sorted_pending_q.size(), beat);
            end
            // block rearms for the next run, lfsr keeps going
            shadow_count   = 0;
            shadow_dropped = 1'b0;
        end
    endtask

    // mix of full-range, near-zero and extreme values so duplicates are common
    function automatic logic [DW-1:0] draw_value();
        logic [DW-1:0] v;
        case ($urandom_range(0, 3))
            0: begin
                v = DW'(int'($urandom_range(0, 8)) - 4);
            end
            1: begin
                case ($urandom_range(0, 3))
                    0:       v = {1'b1, {(DW-1){1'b0}}};
                    1:       v = {1'b0, {(DW-1){1'b1}}};
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    task automatic push_load(input logic [DW-1:0] v, input logic is_last);
        t_load_beat b;
        b.value   = v;
        b.is_last = is_last;
        load_q.insert(load_q.size(), b);
    endtask

    // a run of random values, mark on the final one
    task automatic queue_run(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            push_load(draw_value(), k == len - 1);
        end
    endtask

    // mostly short runs, now and then one around or past capacity
    function automatic int pick_run_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(DEPTH - 2, DEPTH + 6);
        end
        return $urandom_range(1, 12);
    endfunction

    // load side: offer a beat when the channel is free, accepted beats feed
    // the shadow store
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                load_and_sort(item_if.value, item_if.last_item);
            end
            if (!item_if.valid || item_if.ready) begin
                if (load_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_load = load_q.pop_front();
                    item_if.valid     <= 1'b1;
                    item_if.value     <= next_load.value;
                    item_if.last_item <= next_load.is_last;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // result side: random back-pressure, every accepted beat checked against
    // the oldest pending sorted value
    always @(posedge i_clk) begin : watch_results
        t_sorted_beat want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (sorted_pending_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result beat: value %0d final %b overflowed %b",
                                 $signed(result_if.sorted_value), result_if.final_result,
                                 result_if.overflowed);
                    end
                end else begin
                    want = sorted_pending_q.pop_front();
                    if (result_if.sorted_value !== want.value
                            || result_if.final_result !== want.is_final
                            || result_if.overflowed !== want.overflowed) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result mismatch: want %0d/%b/%b got %0d/%b/%b",
                                     $signed(want.value), want.is_final, want.overflowed,
                                     $signed(result_if.sorted_value),
                                     result_if.final_result, result_if.overflowed);
                        end
                    end
                end
            end
            result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        int ph;
        int queued;
        int len;
        // every block input known from time zero
        i_rst_n           = 1'b0;
        item_if.valid     = 1'b0;
        item_if.value     = '0;
        item_if.last_item = 1'b0;
        result_if.ready   = 1'b0;
        shadow_count      = 0;
        shadow_dropped    = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        mismatch_count    = 0;
        cycle_count       = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phases: free-running, sparse loads, heavy back-pressure, both mild
        for (ph = 0; ph < 4; ph++) begin
            @(negedge i_clk);
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase

            if (ph == 0) begin
                // one-element run at the most negative value
                push_load({1'b1, {(DW-1){1'b0}}}, 1'b1);
                // both extremes, zero and the values around it
                push_load({1'b0, {(DW-1){1'b1}}}, 1'b0);
                push_load({1'b1, {(DW-1){1'b0}}}, 1'b0);
                push_load('0, 1'b0);
                push_load('1, 1'b0);
                push_load(DW'(1), 1'b1);
                // all equal keys
                repeat (3) push_load(DW'(5), 1'b0);
                push_load(DW'(5), 1'b1);
                // strictly descending input
                for (len = 6; len >= 1; len--) begin
                    push_load(DW'(len), len == 1);
                end
                // two-element run, one negative
                push_load(DW'(3), 1'b0);
                push_load(DW'(-3), 1'b1);
                // store exactly full
                queue_run(DEPTH);
            end
            if (ph == 2) begin
                // past capacity: the closing value itself is dropped
                queue_run(DEPTH + 3);
            end

            queued = 0;
            while (queued < PHASE_ITEMS) begin
                len = pick_run_len();
                queue_run(len);
                queued += len;
            end

            // hold off new loads until every sorted value has come back
            while (load_q.size() != 0 || item_if.valid || sorted_pending_q.size() != 0) begin
                @(negedge i_clk);
            end
        end

        // settle time for any stray beat
        repeat (40) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
